// ===== sv/nhs_pkg.sv =====
package nhs_pkg;

    localparam int NODE_FW = 8;

    typedef enum logic [2:0] {
        CMD_WR_NODE = 3'd0,
        CMD_WR_LINK = 3'd1,
        CMD_WR_DIST = 3'd2,
        CMD_TOWARD  = 3'd3,
        CMD_AWAY    = 3'd4,
        CMD_ALT     = 3'd5
    } cmd_e;

    typedef struct packed {
        logic [2:0]         command;
        logic [NODE_FW-1:0] node;
        logic [3:0]         slot;
        logic [NODE_FW-1:0] target_node;
        logic [31:0]        net_mask;
        logic [4:0]         link_count;
        logic [23:0]        distance;
    } req_word_t;

    typedef struct packed {
        logic [NODE_FW-1:0] next_node;
        logic               found;
    } rsp_word_t;

    typedef struct packed {
        logic node;
        logic link;
        logic dist_tab;
    } tbl_we_t;

    typedef struct packed {
        logic       init;
        logic       preset;
        logic       step;
        logic [2:0] mode;
    } pick_ctrl_t;

    typedef struct packed {
        logic [NODE_FW-1:0] lk;
        logic               hit;
        logic               unreach;
    } cand_t;

endpackage

// ===== sv/next_hop_select.sv =====
// channel | direction | word                 | handshake
// req     | in        | nhs_pkg::req_word_t  | req_valid / req_stall
// rsp     | out       | nhs_pkg::rsp_word_t  | rsp_valid / rsp_stall
//
// A write word lands in its table when accepted; writes may follow each other every cycle.
// A query reads the node table and, unless nothing is to be scanned, streams its
// links through the link table, then the node and distance tables, one per cycle,
// into one compare unit, and loads its result in the finish state. The next word is
// taken once the load returns to idle. Tables are not cleared by reset. A waiting
// result lets new words in; a query done while the result is stalled waits until it frees.
module next_hop_select #(
    parameter int NUM_NODES = 256,
    parameter int MAX_LINKS = 16,
    parameter int DIST_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  nhs_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output nhs_pkg::rsp_word_t rsp
);

    localparam int NODE_AW = $clog2(NUM_NODES);
    localparam int CNT_W   = $clog2(MAX_LINKS + 1);
    localparam int LINK_AW = $clog2(NUM_NODES * MAX_LINKS);
    localparam int DIST_AW = $clog2(NUM_NODES * NUM_NODES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_COUNT  = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]                  q_cmd_reg;
    logic [nhs_pkg::NODE_FW-1:0] q_node_reg, q_dest_reg;
    logic [31:0]                 q_net_reg;
    logic [NODE_AW-1:0]          q_src_idx_reg, q_dest_idx_reg;
    logic                        q_src_ok_reg, q_dest_ok_reg;
    logic [CNT_W-1:0]            links_reg, links_next;
    logic [CNT_W-1:0]            issue_reg, issue_next;
    logic                        v1_reg, v1_next, v2_reg;
    logic [nhs_pkg::NODE_FW-1:0] lk2_reg;
    logic                        lk2_ok_reg;
    logic                        rsp_valid_reg, rsp_valid_next;
    nhs_pkg::rsp_word_t          rsp_reg;

    logic                        accept, is_query, load_rsp, issue_go;
    logic [31:0]                 node_w, dest_w, slot_w, cnt_w, dist_w, lk_w, sat_w;
    logic                        node_ok, dest_ok, slot_ok, lk_ok;
    logic [NODE_AW-1:0]          node_idx, dest_idx, lk_idx;

    nhs_pkg::tbl_we_t            we;
    logic [LINK_AW-1:0]          link_waddr, link_raddr;
    logic [DIST_AW-1:0]          dist_waddr, dist_raddr;
    logic [NODE_AW-1:0]          node_raddr;
    logic [31:0]                 node_rmask;
    logic [CNT_W-1:0]            node_rcount;
    logic [nhs_pkg::NODE_FW-1:0] link_rdata;
    logic [DIST_BITS-1:0]        dist_rdata;

    nhs_pkg::pick_ctrl_t         pick_ctrl;
    nhs_pkg::cand_t              cand;
    logic                        pick_found;
    logic [nhs_pkg::NODE_FW-1:0] pick_choice;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign is_query  = (req.command == nhs_pkg::CMD_TOWARD) ||
                       (req.command == nhs_pkg::CMD_AWAY) ||
                       (req.command == nhs_pkg::CMD_ALT);

    assign node_w   = 32'(req.node);
    assign dest_w   = 32'(req.target_node);
    assign slot_w   = 32'(req.slot);
    assign cnt_w    = 32'(req.link_count);
    assign dist_w   = 32'(req.distance);
    assign node_ok  = node_w < NUM_NODES;
    assign dest_ok  = dest_w < NUM_NODES;
    assign slot_ok  = slot_w < MAX_LINKS;
    assign node_idx = node_w[NODE_AW-1:0];
    assign dest_idx = dest_w[NODE_AW-1:0];
    assign sat_w    = (cnt_w > MAX_LINKS) ? 32'(MAX_LINKS) : cnt_w;

    assign lk_w   = 32'(link_rdata);
    assign lk_ok  = lk_w < NUM_NODES;
    assign lk_idx = lk_w[NODE_AW-1:0];

    // table writes land on the accept edge
    assign we.node     = accept && (req.command == nhs_pkg::CMD_WR_NODE) && node_ok;
    assign we.link     = accept && (req.command == nhs_pkg::CMD_WR_LINK) && node_ok && slot_ok;
    assign we.dist_tab = accept && (req.command == nhs_pkg::CMD_WR_DIST) && node_ok && dest_ok;

    assign link_waddr = LINK_AW'(node_idx) * LINK_AW'(MAX_LINKS) + LINK_AW'(slot_w[CNT_W-1:0]);
    assign dist_waddr = DIST_AW'(node_idx) * DIST_AW'(NUM_NODES) + DIST_AW'(dest_idx);

    assign issue_go   = (state_reg == S_SCAN) && (issue_reg < links_reg);
    assign node_raddr = (state_reg == S_IDLE) ? node_idx : lk_idx;
    assign link_raddr = LINK_AW'(q_src_idx_reg) * LINK_AW'(MAX_LINKS) + LINK_AW'(issue_reg);
    assign dist_raddr = DIST_AW'(lk_idx) * DIST_AW'(NUM_NODES) + DIST_AW'(q_dest_idx_reg);

    nhs_tables #(
        .NUM_NODES (NUM_NODES),
        .MAX_LINKS (MAX_LINKS),
        .DIST_BITS (DIST_BITS)
    ) u_tables (
        .clk         (clk),
        .we          (we),
        .node_waddr  (node_idx),
        .node_wmask  (req.net_mask),
        .node_wcount (sat_w[CNT_W-1:0]),
        .link_waddr  (link_waddr),
        .link_wdata  (req.target_node),
        .dist_waddr  (dist_waddr),
        .dist_wdata  (dist_w[DIST_BITS-1:0]),
        .node_raddr  (node_raddr),
        .node_rmask  (node_rmask),
        .node_rcount (node_rcount),
        .link_raddr  (link_raddr),
        .link_rdata  (link_rdata),
        .dist_raddr  (dist_raddr),
        .dist_rdata  (dist_rdata)
    );

    assign cand.lk      = lk2_reg;
    assign cand.hit     = lk2_ok_reg && ((node_rmask & q_net_reg) != '0);
    assign cand.unreach = !lk2_ok_reg || !q_dest_ok_reg || (dist_rdata == '1);

    always_comb
    begin
        pick_ctrl.init   = (state_reg == S_COUNT);
        pick_ctrl.preset = (state_reg == S_COUNT) && q_src_ok_reg &&
                           (q_cmd_reg != nhs_pkg::CMD_ALT) && (q_node_reg == q_dest_reg);
        pick_ctrl.step   = (state_reg == S_SCAN) && v2_reg;
        pick_ctrl.mode   = q_cmd_reg;
    end

    nhs_pick #(
        .DIST_BITS (DIST_BITS)
    ) u_pick (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (pick_ctrl),
        .preset_node (q_node_reg),
        .dest        (q_dest_reg),
        .cand        (cand),
        .cand_dist   (dist_rdata),
        .found       (pick_found),
        .choice      (pick_choice)
    );

    assign load_rsp = (state_reg == S_FINISH) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next     = state_reg;
        links_next     = links_reg;
        issue_next     = issue_reg;
        v1_next        = issue_go;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_query)
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                links_next = node_rcount;
                issue_next = '0;
                if (!q_src_ok_reg || pick_ctrl.preset || node_rcount == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue_go)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                else if (!v1_reg && !v2_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (load_rsp)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            links_reg     <= '0;
            issue_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            links_reg     <= links_next;
            issue_reg     <= issue_next;
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_cmd_reg      <= req.command;
            q_node_reg     <= req.node;
            q_dest_reg     <= req.target_node;
            q_net_reg      <= req.net_mask;
            q_src_idx_reg  <= node_idx;
            q_dest_idx_reg <= dest_idx;
            q_src_ok_reg   <= node_ok;
            q_dest_ok_reg  <= dest_ok;
        end
        lk2_reg    <= link_rdata;
        lk2_ok_reg <= lk_ok;
        if (load_rsp)
        begin
            rsp_reg.found     <= pick_found;
            rsp_reg.next_node <= pick_found ? pick_choice : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg) |-> (state_reg == S_SCAN))
        else $error("link pipeline busy outside scan");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_reg <= links_reg))
        else $error("link issue ran past link count");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish");
`endif

endmodule

// ===== sv/nhs_tables.sv =====
module nhs_tables #(
    parameter int NUM_NODES = 256,
    parameter int MAX_LINKS = 16,
    parameter int DIST_BITS = 24
) (
    input  logic                                  clk,
    input  nhs_pkg::tbl_we_t                      we,
    input  logic [$clog2(NUM_NODES)-1:0]          node_waddr,
    input  logic [31:0]                           node_wmask,
    input  logic [$clog2(MAX_LINKS+1)-1:0]        node_wcount,
    input  logic [$clog2(NUM_NODES*MAX_LINKS)-1:0] link_waddr,
    input  logic [nhs_pkg::NODE_FW-1:0]           link_wdata,
    input  logic [$clog2(NUM_NODES*NUM_NODES)-1:0] dist_waddr,
    input  logic [DIST_BITS-1:0]                  dist_wdata,
    input  logic [$clog2(NUM_NODES)-1:0]          node_raddr,
    output logic [31:0]                           node_rmask,
    output logic [$clog2(MAX_LINKS+1)-1:0]        node_rcount,
    input  logic [$clog2(NUM_NODES*MAX_LINKS)-1:0] link_raddr,
    output logic [nhs_pkg::NODE_FW-1:0]           link_rdata,
    input  logic [$clog2(NUM_NODES*NUM_NODES)-1:0] dist_raddr,
    output logic [DIST_BITS-1:0]                  dist_rdata
);

    localparam int CNT_W = $clog2(MAX_LINKS + 1);

    logic [CNT_W+31:0]               node_mem [NUM_NODES];
    logic [nhs_pkg::NODE_FW-1:0]     link_mem [NUM_NODES*MAX_LINKS];
    logic [DIST_BITS-1:0]            dist_mem [NUM_NODES*NUM_NODES];
    logic [CNT_W+31:0]               node_rd_reg;

    always_ff @(posedge clk)
    begin
        if (we.node)
        begin
            node_mem[node_waddr] <= {node_wcount, node_wmask};
        end
        node_rd_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.link)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.dist_tab)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rdata <= dist_mem[dist_raddr];
    end

    assign node_rmask  = node_rd_reg[31:0];
    assign node_rcount = node_rd_reg[CNT_W+31:32];

endmodule

// ===== sv/nhs_pick.sv =====
module nhs_pick #(
    parameter int DIST_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nhs_pkg::pick_ctrl_t         ctrl,
    input  logic [nhs_pkg::NODE_FW-1:0] preset_node,
    input  logic [nhs_pkg::NODE_FW-1:0] dest,
    input  nhs_pkg::cand_t              cand,
    input  logic [DIST_BITS-1:0]        cand_dist,
    output logic                        found,
    output logic [nhs_pkg::NODE_FW-1:0] choice
);

    logic                        found_reg, found_next;
    logic                        best_neg_reg, best_neg_next;
    logic [nhs_pkg::NODE_FW-1:0] choice_reg, choice_next;
    logic [DIST_BITS-1:0]        best_reg, best_next;

    // one candidate compared per step; the mode picks the comparison and how the result is used
    always_comb
    begin
        found_next    = found_reg;
        best_neg_next = best_neg_reg;
        choice_next   = choice_reg;
        best_next     = best_reg;
        if (ctrl.init)
        begin
            found_next    = 1'b0;
            best_neg_next = 1'b1;
            best_next     = '0;
        end
        if (ctrl.preset)
        begin
            found_next  = 1'b1;
            choice_next = preset_node;
        end
        if (ctrl.step)
        begin
            case (ctrl.mode)
                nhs_pkg::CMD_TOWARD:
                begin
                    if (!cand.unreach && cand.hit && (!found_reg || cand_dist < best_reg))
                    begin
                        found_next  = 1'b1;
                        choice_next = cand.lk;
                        best_next   = cand_dist;
                    end
                end
                nhs_pkg::CMD_AWAY:
                begin
                    // unreachable ranks as -1, below every real distance
                    if (best_neg_reg || (!cand.unreach && cand_dist > best_reg))
                    begin
                        found_next    = cand.hit;
                        choice_next   = cand.hit ? cand.lk : '0;
                        best_next     = cand_dist;
                        best_neg_next = cand.unreach;
                    end
                end
                nhs_pkg::CMD_ALT:
                begin
                    if (!found_reg && cand.hit && cand.lk != dest)
                    begin
                        found_next  = 1'b1;
                        choice_next = cand.lk;
                    end
                end
                default:
                begin
                    found_next = found_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            best_neg_reg <= 1'b1;
        end
        else
        begin
            found_reg    <= found_next;
            best_neg_reg <= best_neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        choice_reg <= choice_next;
        best_reg   <= best_next;
    end

    assign found  = found_reg;
    assign choice = choice_reg;

endmodule

// ===== tb/next_hop_checker.sv =====
module next_hop_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  nhs_pkg::req_word_t req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  nhs_pkg::rsp_word_t rsp,
    output int                 mismatches,
    output int                 hops_awaiting
);

    localparam int          MAX_LINKS   = 16;
    localparam logic [23:0] UNREACHABLE = '1;

    logic [31:0]        node_mask  [256];
    logic [4:0]         node_links [256];
    logic [7:0]         link_tgt   [4096];
    logic [23:0]        hop_dist   [65536];
    nhs_pkg::rsp_word_t hops_due   [$];
    int                 errs = 0;

    assign mismatches = errs;

    initial hops_awaiting = 0;

    function automatic nhs_pkg::rsp_word_t predict_next_hop(nhs_pkg::req_word_t w);
        nhs_pkg::rsp_word_t pick;
        logic [7:0]         lk;
        logic [23:0]        d;
        logic [23:0]        least;
        logic signed [25:0] most;
        logic signed [25:0] ranked;
        logic               hit;
        int                 n;
        pick  = '0;
        least = '0;
        most  = -26'sd1;
        n     = int'(node_links[w.node]);
        if (w.command != nhs_pkg::CMD_ALT && w.node == w.target_node)
        begin
            pick.found     = 1'b1;
            pick.next_node = w.node;
            return pick;
        end
        for (int i = 0; i < n; i++)
        begin
            lk  = link_tgt[{w.node, 4'(i)}];
            d   = hop_dist[{lk, w.target_node}];
            hit = (node_mask[lk] & w.net_mask) != '0;
            case (w.command)
                nhs_pkg::CMD_TOWARD:
                begin
                    if (d != UNREACHABLE && (!pick.found || d < least) && hit)
                    begin
                        pick.found     = 1'b1;
                        pick.next_node = lk;
                        least          = d;
                    end
                end
                nhs_pkg::CMD_AWAY:
                begin
                    // unreachable ranks as -1, which also means nothing taken yet
                    ranked = (d == UNREACHABLE) ? -26'sd1 : $signed({2'b00, d});
                    if (most == -26'sd1 || ranked > most)
                    begin
                        pick.found     = hit;
                        pick.next_node = hit ? lk : '0;
                        most           = ranked;
                    end
                end
                default:
                begin
                    if (!pick.found && lk != w.target_node && hit)
                    begin
                        pick.found     = 1'b1;
                        pick.next_node = lk;
                    end
                end
            endcase
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        nhs_pkg::rsp_word_t due;
        if (!rst_n)
        begin
            hops_due.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (hops_due.size() == 0)
                begin
                    $display("%0t: response word %h with no query outstanding", $time, rsp);
                    errs++;
                end
                else
                begin
                    due = hops_due.pop_front();
                    if (rsp.found !== due.found)
                    begin
                        $display("%0t: found expected %b got %b", $time, due.found, rsp.found);
                        errs++;
                    end
                    if (rsp.next_node !== due.next_node)
                    begin
                        $display("%0t: next_node expected %0d got %0d",
                                 $time, due.next_node, rsp.next_node);
                        errs++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                case (req.command)
                    nhs_pkg::CMD_WR_NODE:
                    begin
                        node_mask[req.node]  = req.net_mask;
                        node_links[req.node] = (req.link_count > 5'(MAX_LINKS)) ?
                                               5'(MAX_LINKS) : req.link_count;
                    end
                    nhs_pkg::CMD_WR_LINK: link_tgt[{req.node, req.slot}] = req.target_node;
                    nhs_pkg::CMD_WR_DIST: hop_dist[{req.node, req.target_node}] = req.distance;
                    nhs_pkg::CMD_TOWARD, nhs_pkg::CMD_AWAY, nhs_pkg::CMD_ALT:
                        hops_due.push_back(predict_next_hop(req));
                    default: ;
                endcase
            end
        end
        hops_awaiting = hops_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;

    localparam int         ITEMS     = 1100;
    localparam int         WATCHDOG  = 3000;
    localparam int         POOL      = 20;
    localparam int         MAX_LINKS = 16;
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    nhs_pkg::req_word_t req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    nhs_pkg::rsp_word_t rsp;
    int                 mismatches;
    int                 hops_awaiting;

    int         idle_pct   = 0;
    int         stall_pct  = 0;
    int         words_sent = 0;
    bit         mask_known [256];
    bit         link_known [4096];
    bit         dist_known [65536];
    logic [7:0] link_to    [4096];
    int         links_of   [256];
    logic [7:0] pool       [POOL];

    always #5 clk = ~clk;

    next_hop_select u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    next_hop_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .hops_awaiting (hops_awaiting)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic nhs_pkg::req_word_t noisy_word(logic [2:0] c);
        logic [95:0]        bits;
        nhs_pkg::req_word_t w;
        bits      = {$urandom, $urandom, $urandom};
        w         = bits[$bits(nhs_pkg::req_word_t)-1:0];
        w.command = c;
        return w;
    endfunction

    function automatic logic [31:0] rand_mask();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return 32'd1 << $urandom_range(31);
            default: return $urandom & $urandom;
        endcase
    endfunction

    function automatic logic [23:0] rand_dist();
        case ($urandom_range(9))
            0, 1:    return '1;
            2, 3, 4: return 24'($urandom_range(7));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [4:0] rand_count();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 5'($urandom_range(31, 7));
            default: return 5'($urandom_range(5, 1));
        endcase
    endfunction

    function automatic logic [7:0] pool_node();
        if ($urandom_range(6) == 0)
            return 8'($urandom_range(255));
        return pool[$urandom_range(POOL - 1)];
    endfunction

    function automatic logic [7:0] pick_node(logic [7:0] src, logic [7:0] dst);
        case ($urandom_range(9))
            0:       return dst;
            1:       return src;
            default: return pool_node();
        endcase
    endfunction

    task automatic send_word(input nhs_pkg::req_word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (w.command <= nhs_pkg::CMD_ALT)
            words_sent++;
        // track what has been written so that no query reads an empty entry
        case (w.command)
            nhs_pkg::CMD_WR_NODE:
            begin
                mask_known[w.node] = 1'b1;
                links_of[w.node]   = (w.link_count > 5'(MAX_LINKS)) ?
                                     MAX_LINKS : int'(w.link_count);
            end
            nhs_pkg::CMD_WR_LINK:
            begin
                link_known[{w.node, w.slot}] = 1'b1;
                link_to[{w.node, w.slot}]    = w.target_node;
            end
            nhs_pkg::CMD_WR_DIST: dist_known[{w.node, w.target_node}] = 1'b1;
            default: ;
        endcase
    endtask

    task automatic write_node(input logic [7:0] n, input logic [31:0] m,
                              input logic [4:0] cnt);
        nhs_pkg::req_word_t w;
        w            = noisy_word(nhs_pkg::CMD_WR_NODE);
        w.node       = n;
        w.net_mask   = m;
        w.link_count = cnt;
        send_word(w);
    endtask

    task automatic write_link(input logic [7:0] n, input logic [3:0] s,
                              input logic [7:0] tgt);
        nhs_pkg::req_word_t w;
        w             = noisy_word(nhs_pkg::CMD_WR_LINK);
        w.node        = n;
        w.slot        = s;
        w.target_node = tgt;
        send_word(w);
    endtask

    task automatic write_dist(input logic [7:0] from, input logic [7:0] to,
                              input logic [23:0] d);
        nhs_pkg::req_word_t w;
        w             = noisy_word(nhs_pkg::CMD_WR_DIST);
        w.node        = from;
        w.target_node = to;
        w.distance    = d;
        send_word(w);
    endtask

    task automatic query(input logic [2:0] c, input logic [7:0] src,
                         input logic [7:0] dst, input logic [31:0] m);
        nhs_pkg::req_word_t w;
        w             = noisy_word(c);
        w.node        = src;
        w.target_node = dst;
        w.net_mask    = m;
        send_word(w);
    endtask

    // fill in whatever a query from src to dst would read, refreshing a little at random
    task automatic arrange_route(input logic [7:0] src, input logic [7:0] dst);
        logic [7:0] hop;
        int         idx;
        if (!mask_known[src] || $urandom_range(7) == 0)
            write_node(src, rand_mask(), rand_count());
        for (idx = 0; idx < links_of[src]; idx++)
        begin
            if (!link_known[{src, 4'(idx)}] || $urandom_range(9) == 0)
                write_link(src, 4'(idx), pick_node(src, dst));
            hop = link_to[{src, 4'(idx)}];
            if (!mask_known[hop])
                write_node(hop, rand_mask(), rand_count());
            if (!dist_known[{hop, dst}] || $urandom_range(9) == 0)
                write_dist(hop, dst, rand_dist());
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] src;
        logic [7:0] dst;
        int         roll;
        foreach (pool[i])
            pool[i] = 8'($urandom_range(255));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small graph: node 0 links to 255 (off every network), 1 and 2
        write_node(8'd0, '1, 5'd3);
        write_node(8'd255, '0, 5'd31);
        write_node(8'd1, 32'h0000_0001, 5'd0);
        write_node(8'd2, 32'h8000_0000, 5'd0);
        write_link(8'd0, 4'd0, 8'd255);
        write_link(8'd0, 4'd1, 8'd1);
        write_link(8'd0, 4'd2, 8'd2);
        write_dist(8'd255, 8'd2, '0);
        write_dist(8'd1, 8'd2, '1);
        write_dist(8'd2, 8'd2, '0);
        write_dist(8'd255, 8'd1, 24'd7);
        write_dist(8'd1, 8'd1, '0);
        write_dist(8'd2, 8'd1, 24'd7);
        query(nhs_pkg::CMD_TOWARD, 8'd0, 8'd2, '1);
        query(nhs_pkg::CMD_TOWARD, 8'd0, 8'd2, '0);
        query(nhs_pkg::CMD_AWAY, 8'd0, 8'd2, '1);
        query(nhs_pkg::CMD_ALT, 8'd0, 8'd2, 32'h0000_0001);
        query(nhs_pkg::CMD_ALT, 8'd0, 8'd1, '1);
        query(nhs_pkg::CMD_TOWARD, 8'd0, 8'd1, '1);
        query(nhs_pkg::CMD_TOWARD, 8'd0, 8'd1, 32'h8000_0000);
        query(nhs_pkg::CMD_AWAY, 8'd0, 8'd1, '1);
        query(nhs_pkg::CMD_TOWARD, 8'd1, 8'd1, '1);
        query(nhs_pkg::CMD_AWAY, 8'd2, 8'd2, '1);
        query(nhs_pkg::CMD_TOWARD, 8'd2, 8'd1, '1);
        send_word(noisy_word(CMD_SPARE_LO));
        send_word(noisy_word(CMD_SPARE_HI));

        while (words_sent < ITEMS)
        begin
            case (words_sent * 4 / ITEMS)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            roll = $urandom_range(99);
            if (roll < 60)
            begin
                src = pool_node();
                dst = ($urandom_range(9) == 0) ? src : pool_node();
                arrange_route(src, dst);
                repeat ($urandom_range(3, 1))
                    query(3'($urandom_range(nhs_pkg::CMD_ALT, nhs_pkg::CMD_TOWARD)),
                          src, dst, rand_mask());
            end
            else if (roll < 94)
                send_word(noisy_word(3'($urandom_range(nhs_pkg::CMD_WR_DIST,
                                                       nhs_pkg::CMD_WR_NODE))));
            else
                send_word(noisy_word(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO))));
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (hops_awaiting != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && hops_awaiting == 0)
            $display("next_hop_select verification clean");
        else
            $display("next_hop_select verification failed");
        $finish;
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("next_hop_select verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/nhs_pkg.sv
sv/nhs_tables.sv
sv/nhs_pick.sv
sv/next_hop_select.sv
tb/next_hop_checker.sv
tb/testbench.sv
